>>> rtl/b2da_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the binary to decimal ASCII converter.
// No dependencies; used by b2da_bcd_cell and binary_to_decimal_ascii_core.
package b2da_pkg;

   localparam int DEFAULT_VALUE_BITS = 32;
   localparam int MAX_VALUE_BITS     = 64;
   localparam int IN_BITS            = 32;
   localparam int DIGIT_W            = 4;
   localparam int CHAR_W             = 7;

   localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'd48;
   localparam logic [CHAR_W-1:0]  CHAR_MINUS = 7'd45;
   localparam logic [DIGIT_W-1:0] ADJ_LIMIT  = 4'd5;
   localparam logic [DIGIT_W-1:0] ADJ_ADD    = 4'd3;
   localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;

   typedef struct packed {
      logic [IN_BITS-1:0] value;
      logic               signed_mode;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] ascii_char;
      logic              last;
   } rsp_type;

   // Per-cycle command broadcast to every BCD cell
   typedef struct packed {
      logic clear;    // zero the digit
      logic convert;  // double-dabble step: add-3 then shift in a bit
      logic move;     // take the lower neighbor's digit
   } cell_ctrl_type;

endpackage

>>> rtl/b2da_bcd_cell.sv
`timescale 1ns / 1ps
// One BCD digit of the double-dabble chain.
// Depends on b2da_pkg for cell_ctrl_type and digit constants.
module b2da_bcd_cell (
   input  logic                          clock,
   input  b2da_pkg::cell_ctrl_type       ctrl,
   input  logic                          bit_in,
   input  logic [b2da_pkg::DIGIT_W-1:0]  digit_lower,
   output logic                          bit_out,
   output logic [b2da_pkg::DIGIT_W-1:0]  digit
);
   import b2da_pkg::*;

   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] digit_in;
   logic [DIGIT_W-1:0] adjusted;

   assign adjusted = (digit_ff >= ADJ_LIMIT) ? (digit_ff + ADJ_ADD) : digit_ff;
   assign bit_out  = adjusted[DIGIT_W-1];
   assign digit    = digit_ff;

   always_comb begin
      digit_in = digit_ff;
      if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.convert) begin
         digit_in = {adjusted[DIGIT_W-2:0], bit_in};
      end else if (ctrl.move) begin
         digit_in = digit_lower;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule

>>> rtl/binary_to_decimal_ascii_core.sv
`timescale 1ns / 1ps
// Binary word to decimal ASCII text, one character per result item.
// Depends on b2da_pkg and b2da_bcd_cell.
//
//  channel | ports                      | handshake
//  --------+----------------------------+---------------------------------
//  request | start, busy, req_data      | taken when start && !busy
//  result  | rsp_valid, rsp_data        | one-cycle strobe, no back-pressure
//
// An item is shifted bit by bit through the BCD cell chain in ST_CONVERT,
// then ST_SIGN issues a '-' when negative, then ST_EMIT takes one digit cell
// at a time from the top (floor(VALUE_BITS*log10 2)+1 cells); leading zero
// cells are skipped silently. busy drops as the last char reaches the ports,
// so the next item is taken at the edge that takes the last char.
// No stalls: the receiver takes every char. Synchronous reset returns to idle.
module binary_to_decimal_ascii_core #(
   parameter int VALUE_BITS = b2da_pkg::DEFAULT_VALUE_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  b2da_pkg::req_type req_data,
   output logic              rsp_valid,
   output b2da_pkg::rsp_type rsp_data
);
   import b2da_pkg::*;

   localparam int Digits  = (VALUE_BITS * 1233) / 4096 + 1;
   localparam int BitCntW = $clog2(VALUE_BITS);
   localparam int DigCntW = $clog2(Digits + 1);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_CONVERT = 4'b0010,
      ST_SIGN    = 4'b0100,
      ST_EMIT    = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] shift_ff, shift_in;
   logic [BitCntW-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [DigCntW-1:0]    dig_cnt_ff, dig_cnt_in;
   logic                  neg_ff, neg_in;
   logic                  started_ff, started_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic [MAX_VALUE_BITS-1:0] wide_value;
   logic [VALUE_BITS-1:0]     word;
   logic [VALUE_BITS-1:0]     mag;
   logic                      neg;
   logic                      accept;
   logic                      emit_now;
   logic                      final_digit;
   cell_ctrl_type             ctrl;

   logic [DIGIT_W-1:0] digits [Digits];
   logic               carry  [Digits+1];

   // Bits above VALUE_BITS are dropped; above 32 the word is zero-extended.
   assign wide_value = MAX_VALUE_BITS'(req_data.value);
   assign word       = wide_value[VALUE_BITS-1:0];
   assign neg        = req_data.signed_mode & word[VALUE_BITS-1];
   assign mag        = neg ? VALUE_BITS'(~word + 1'b1) : word;

   assign accept      = start && (state_ff == ST_IDLE);
   assign busy        = (state_ff != ST_IDLE);
   assign final_digit = (dig_cnt_ff == DigCntW'(1));
   assign emit_now    = started_ff || (digits[Digits-1] != '0) || final_digit;

   assign carry[0] = shift_ff[VALUE_BITS-1];

   genvar gi;
   generate
      for (gi = 0; gi < Digits; gi++) begin : g_cell
         logic [DIGIT_W-1:0] lower_digit;
         if (gi == 0) begin : g_first
            assign lower_digit = '0;
         end else begin : g_rest
            assign lower_digit = digits[gi-1];
         end
         b2da_bcd_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .bit_in      (carry[gi]),
            .digit_lower (lower_digit),
            .bit_out     (carry[gi+1]),
            .digit       (digits[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      shift_in     = shift_ff;
      bit_cnt_in   = bit_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      neg_in       = neg_ff;
      started_in   = started_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      ctrl         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctrl.clear = 1'b1;
               shift_in   = mag;
               bit_cnt_in = '0;
               neg_in     = neg;
               started_in = 1'b0;
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            ctrl.convert = 1'b1;
            shift_in     = shift_ff << 1;
            bit_cnt_in   = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == BitCntW'(VALUE_BITS - 1)) begin
               dig_cnt_in = DigCntW'(Digits);
               state_in   = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            rsp_valid_in           = 1'b1;
            rsp_data_in.ascii_char = CHAR_MINUS;
            rsp_data_in.last       = 1'b0;
            state_in               = ST_EMIT;
         end
         ST_EMIT: begin
            // Top cell holds the most significant remaining digit
            ctrl.move  = 1'b1;
            dig_cnt_in = dig_cnt_ff - 1'b1;
            if (emit_now) begin
               started_in             = 1'b1;
               rsp_valid_in           = 1'b1;
               rsp_data_in.ascii_char = CHAR_ZERO + CHAR_W'(digits[Digits-1]);
               rsp_data_in.last       = final_digit;
            end
            if (final_digit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      shift_ff    <= shift_in;
      bit_cnt_ff  <= bit_cnt_in;
      dig_cnt_ff  <= dig_cnt_in;
      neg_ff      <= neg_in;
      started_ff  <= started_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_start_converts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_CONVERT))
      else $error("accepted item did not enter conversion");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |-> !busy)
      else $error("last character issued while still busy");

   a_digit_bcd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (digits[Digits-1] <= DIGIT_MAX))
      else $error("top cell holds a non-decimal digit");

   a_minus_first: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.ascii_char == CHAR_MINUS)) |-> !rsp_data.last)
      else $error("minus sign marked as last character");

   // The cell row is sized so the magnitude never carries out of the top digit
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONVERT) |-> !carry[Digits])
      else $error("carry out of the top digit cell");

endmodule
